FILE: rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants of the chunked bump allocator
// Status codes, the scan token that moves along the cell chain, and the
// controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned IDX_W    = 8;   // holds any chunk index up to 256 chunks
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CIDX_W   = 4;
  localparam int unsigned COPEN_W  = 5;

  localparam logic [BYTES_W-1:0] CHUNK_BYTES_RESET = 16'd10000;

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CHUNK = 2'd2;

  typedef struct packed {
    logic               active;  // token present in this stage
    logic               skip;    // oversized request, cells leave it alone
    logic               found;   // a chunk has taken the request
    logic               opened;  // the taking chunk was opened by this request
    logic [IDX_W-1:0]   idx;
    logic [BYTES_W-1:0] offset;
    logic [BYTES_W-1:0] req;
  } tok_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage : cba_pkg

`default_nettype wire

FILE: rtl/cba_ifs.sv
// ----------------------------------------------------------------------------
// cba_ifs: channel interfaces of the chunked bump allocator
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cba_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] request_bytes;

  modport source (output valid, output request_bytes, input ready);
  modport sink   (input valid, input request_bytes, output ready);
endinterface : cba_req_if

interface cba_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  chunk_index;
  logic [15:0] block_offset;
  logic [4:0]  chunks_open;

  modport source (output valid, output status, output chunk_index, output block_offset,
                  output chunks_open, input ready);
  modport sink   (input valid, input status, input chunk_index, input block_offset,
                  input chunks_open, output ready);
endinterface : cba_res_if

interface cba_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] chunk_bytes;

  modport source (output valid, output chunk_bytes, input ready);
  modport sink   (input valid, input chunk_bytes, output ready);
endinterface : cba_cfg_if

`default_nettype wire

FILE: rtl/chunked_bump_allocator_top.sv
// ----------------------------------------------------------------------------
// chunked_bump_allocator_top: first-fit bump allocator over a chain of chunks
// A request transfer sends a scan token through the chain of chunk cells, one
// cell per cycle; the result is registered in the output register after the
// last cell. No new request is taken until the scan ends and the controller is idle.
// Reset (rst, synchronous): all chunks closed, chunk size 10000, no result.
// A finished result may wait for the sink while the next request is scanned.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_bump_allocator_top #(
  parameter int unsigned MAX_CHUNKS = 16
) (
  input  wire        clk,
  input  wire        rst,
  cba_req_if.sink    req_ch,
  cba_res_if.source  res_ch,
  cba_cfg_if.sink    cfg_ch
);
  import cba_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned SW = (CW > COPEN_W) ? CW : COPEN_W;

  state_t             state;
  state_t             state_next;
  logic [BYTES_W-1:0] chunk_bytes;
  logic [CW-1:0]      open_count;
  logic [SW-1:0]      open_after;
  tok_t               tok [0:MAX_CHUNKS];
  tok_t               last;
  logic               in_ready;
  logic               accept;

  logic [STATUS_W-1:0] scan_status;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [CIDX_W-1:0]   out_idx;
  logic [BYTES_W-1:0]  out_offset;
  logic [COPEN_W-1:0]  out_open;
  logic                skid_valid;
  logic [STATUS_W-1:0] skid_status;
  logic [CIDX_W-1:0]   skid_idx;
  logic [BYTES_W-1:0]  skid_offset;
  logic [COPEN_W-1:0]  skid_open;
  logic                out_free;

  // Configuration is always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= CHUNK_BYTES_RESET;
    end else if (cfg_ch.valid) begin
      chunk_bytes <= cfg_ch.chunk_bytes;
    end
  end

  // Controller: next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last.active) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller: outputs. A new scan may start while one result is waiting,
  // but not while a second one sits in the skid register.
  always_comb begin
    case (state)
      S_IDLE:  in_ready = !skid_valid;
      S_SCAN:  in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ch.ready = in_ready;
  assign accept       = req_ch.valid && in_ready;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = accept;
    tok[0].skip   = req_ch.request_bytes > chunk_bytes;
    tok[0].req    = req_ch.request_bytes;
  end

  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
    cba_cell #(
      .CellIdx (IDX_W'(i))
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .chunk_bytes (chunk_bytes),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1])
    );
  end

  assign last = tok[MAX_CHUNKS];

  always_comb begin
    if (last.skip) begin
      scan_status = ST_TOO_BIG;
    end else if (last.found) begin
      scan_status = ST_GRANTED;
    end else begin
      scan_status = ST_NO_CHUNK;
    end
    open_after = SW'(open_count) + SW'(last.opened);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_count <= '0;
    end else if (last.active && last.opened) begin
      open_count <= open_count + CW'(1);
    end
  end

  // Output register with one skid entry behind it.
  assign out_free = !out_valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= skid_valid || last.active;
      end
      if (out_free) begin
        skid_valid <= skid_valid && last.active;
      end else if (last.active) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_status <= skid_status;
        out_idx    <= skid_idx;
        out_offset <= skid_offset;
        out_open   <= skid_open;
      end else begin
        out_status <= scan_status;
        out_idx    <= last.idx[CIDX_W-1:0];
        out_offset <= last.offset;
        out_open   <= open_after[COPEN_W-1:0];
      end
    end
    if (last.active && (!out_free || skid_valid)) begin
      skid_status <= scan_status;
      skid_idx    <= last.idx[CIDX_W-1:0];
      skid_offset <= last.offset;
      skid_open   <= open_after[COPEN_W-1:0];
    end
  end

  assign res_ch.valid        = out_valid;
  assign res_ch.status       = out_status;
  assign res_ch.chunk_index  = out_idx;
  assign res_ch.block_offset = out_offset;
  assign res_ch.chunks_open  = out_open;

  a_scan_end_in_scan : assert property (@(posedge clk) disable iff (rst)
    last.active |-> (state == S_SCAN))
    else $error("scan token left the chain outside a scan");

  a_open_bound : assert property (@(posedge clk) disable iff (rst)
    open_count <= CW'(MAX_CHUNKS))
    else $error("open chunk count above chunk limit");

  a_accept_starts_scan : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN))
    else $error("request transfer did not start a scan");

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_result_lost : assert property (@(posedge clk) disable iff (rst)
    (last.active && skid_valid) |-> out_free)
    else $error("scan finished with no room for its result");

endmodule : chunked_bump_allocator_top

`default_nettype wire

FILE: rtl/cba_cell.sv
// ----------------------------------------------------------------------------
// cba_cell: one chunk of the allocator
// Holds the chunk's fill level and open flag. When the scan token passes and
// no earlier chunk took the request, the cell either bumps its fill level if the
// request fits or, if it is the first closed chunk, opens with the request as its fill.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_cell #(
  parameter logic [cba_pkg::IDX_W-1:0] CellIdx = '0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [cba_pkg::BYTES_W-1:0]   chunk_bytes,
  input  cba_pkg::tok_t                tok_in,
  output cba_pkg::tok_t                tok_out
);
  import cba_pkg::*;

  logic               is_open;
  logic [BYTES_W-1:0] fill;
  logic [BYTES_W-1:0] fill_next;
  logic [BYTES_W:0]   used_sum;
  logic               live;
  logic               take_fit;
  logic               take_new;
  tok_t               tok_next;

  always_comb begin
    used_sum  = {1'b0, fill} + {1'b0, tok_in.req};
    live      = tok_in.active && !tok_in.skip && !tok_in.found;
    take_fit  = live && is_open && ({1'b0, chunk_bytes} > used_sum);
    take_new  = live && !is_open;

    tok_next  = tok_in;
    fill_next = fill;
    if (take_fit) begin
      tok_next.found  = 1'b1;
      tok_next.idx    = CellIdx;
      tok_next.offset = fill;
      fill_next       = used_sum[BYTES_W-1:0];
    end else if (take_new) begin
      tok_next.found  = 1'b1;
      tok_next.opened = 1'b1;
      tok_next.idx    = CellIdx;
      tok_next.offset = '0;
      fill_next       = tok_in.req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_open <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (take_new) begin
        is_open <= 1'b1;
      end
    end
  end

  // Fill level is only read once the chunk is open, so it needs no reset.
  always_ff @(posedge clk) begin
    fill <= fill_next;
  end

endmodule : cba_cell

`default_nettype wire

FILE: tb/chunked_bump_allocator_top_test.sv
// ----------------------------------------------------------------------------
// chunked_bump_allocator_top_test: self-checking bench for the bump allocator
// Drives allocation requests and chunk size writes through the valid/ready
// channels, mirrors the first-fit allocator in a scoreboard, and compares
// every result transfer field by field with the predicted allocation.
// ----------------------------------------------------------------------------
module chunked_bump_allocator_top_test;
  import cba_pkg::*;

  localparam int unsigned NUM_CHUNKS    = 16;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 2 * (NUM_CHUNKS + 1) + 6;
  localparam int unsigned PLAN_LEN      = 13;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chunk_index;
    logic [15:0] block_offset;
    logic [4:0]  chunks_open;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [15:0]   capacity;
    logic [15:0]   fill[NUM_CHUNKS];
    int unsigned   open_count;
    alloc_result_t expected_q[$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   granted;
    int unsigned   too_big;
    int unsigned   no_chunk;

    function new();
      capacity   = CHUNK_BYTES_RESET;
      open_count = 0;
      errors     = 0;
      checked    = 0;
      granted    = 0;
      too_big    = 0;
      no_chunk   = 0;
    endfunction

    function void set_capacity(logic [15:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // First-fit over the open chunks; the fit is strict, so a chunk must keep
    // at least one byte free after the block is placed.
    function void note_request(logic [15:0] req);
      alloc_result_t r;
      int unsigned   i;
      int unsigned   hit;
      bit            found;
      r     = '0;
      found = 1'b0;
      hit   = 0;
      r.status = ST_GRANTED;
      if (req > capacity) begin
        r.status = ST_TOO_BIG;
      end else begin
        for (i = 0; i < open_count && !found; i++) begin
          if (32'(capacity) > 32'(fill[i]) + 32'(req)) begin
            found = 1'b1;
            hit   = i;
          end
        end
        if (found) begin
          r.chunk_index  = 4'(hit);
          r.block_offset = fill[hit];
          fill[hit]      = fill[hit] + req;
        end else if (open_count < NUM_CHUNKS) begin
          r.chunk_index    = 4'(open_count);
          fill[open_count] = req;
          open_count++;
        end else begin
          r.status = ST_NO_CHUNK;
        end
      end
      r.chunks_open = 5'(open_count);
      case (r.status)
        ST_GRANTED: granted++;
        ST_TOO_BIG: too_big++;
        default:    no_chunk++;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, expected none, actual %h",
                 $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        checked++;
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("chunk_index", 32'(want.chunk_index), 32'(got.chunk_index));
        check_field("block_offset", 32'(want.block_offset), 32'(got.block_offset));
        check_field("chunks_open", 32'(want.chunks_open), 32'(got.chunks_open));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned req_gap_max = 17;
  int unsigned res_stall_max = 17;
  int unsigned sizes_used = 1;
  int unsigned plan_size [PLAN_LEN] = '{200, 400, 0, 800, 1600, 3200, 100, 6400,
                                        12800, 25600, 51200, 1, 65535};

  alloc_scoreboard sb = new();

  cba_req_if req_ch();
  cba_res_if res_ch();
  cba_cfg_if cfg_ch();

  chunked_bump_allocator_top #(.MAX_CHUNKS(NUM_CHUNKS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .res_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Starts and ends at a falling edge. Valid stays high after the transfer so
  // that a back-to-back request needs no second assignment in one step.
  task automatic send_request(logic [15:0] req);
    int unsigned gap;
    gap = $urandom_range(req_gap_max);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.request_bytes <= req;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [15:0] value);
    req_ch.valid <= 1'b0;
    wait_drained();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.chunk_bytes <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_capacity(value);
    sizes_used++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly small blocks so chunks fill gradually, plus whole-chunk,
  // oversized and unconstrained requests.
  function automatic logic [15:0] pick_request(int unsigned size);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 16'($urandom_range(size / 8));
    if (roll < 75) return 16'($urandom_range(size));
    if (roll < 83) return size[15:0];
    if (roll < 90 && size < 65535) return 16'($urandom_range(65535, size + 1));
    return 16'($urandom());
  endfunction

  task automatic take_result();
    int unsigned   stall;
    alloc_result_t got;
    stall = $urandom_range(res_stall_max);
    if (stall != 0) begin
      res_ch.ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    res_ch.ready <= 1'b1;
    do @(posedge clk); while (!res_ch.valid);
    got.status       = res_ch.status;
    got.chunk_index  = res_ch.chunk_index;
    got.block_offset = res_ch.block_offset;
    got.chunks_open  = res_ch.chunks_open;
    sb.check_result(got);
    @(negedge clk);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever take_result();
  end

  initial begin
    int unsigned p;
    int unsigned n;
    req_ch.valid         = 1'b0;
    req_ch.request_bytes = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.chunk_bytes   = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset chunk size: empty allocator opens chunk 0, a request equal to the
    // chunk size fills a fresh chunk, oversized requests are rejected.
    send_request(16'd0);
    send_request(16'd10000);
    send_request(16'd10001);
    send_request(16'hFFFF);
    send_request(16'd9999);
    send_request(16'd0);
    send_request(16'd1);
    // Zero chunk size: zero requests always open a new chunk.
    write_capacity(16'd0);
    send_request(16'd0);
    send_request(16'd1);
    send_request(16'd0);
    // Size lowered below existing fill levels.
    write_capacity(16'd1);
    send_request(16'd1);
    send_request(16'd0);
    send_request(16'd2);
    write_capacity(16'hFFFF);
    send_request(16'hFFFF);
    send_request(16'hAAAA);
    send_request(16'h5555);
    send_request(16'h0001);

    for (p = 0; p < PLAN_LEN; p++) begin
      write_capacity(plan_size[p][15:0]);
      case (p % 4)
        0: begin req_gap_max = 17; res_stall_max = 17; end
        1: begin req_gap_max = 0;  res_stall_max = 0;  end
        2: begin req_gap_max = 0;  res_stall_max = 17; end
        default: begin req_gap_max = 17; res_stall_max = 0; end
      endcase
      for (n = 0; n < ((plan_size[p] <= 100) ? 40 : 120); n++) begin
        send_request(pick_request(plan_size[p]));
      end
    end

    req_ch.valid <= 1'b0;
    wait_drained();
    $display("Covered %0d chunk sizes, %0d chunks open at the end.",
             sizes_used, sb.open_count);
    $display("Checked %0d results: %0d granted, %0d oversized, %0d out of chunks.",
             sb.checked, sb.granted, sb.too_big, sb.no_chunk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
